FILE: hdl/dpp_pkg.sv
// Shared types, constants and saturating arithmetic for the distorted pinhole projection.
// No dependencies; dpp_mul, dpp_div and the top level refer to this package by scoped names.
package dpp_pkg;

    // Signed fixed-point word with 28 fraction bits, wide enough for +-2^61.
    typedef logic signed [62:0] t_q;
    typedef logic [2:0]         t_cfg_idx;

    localparam t_q Q_LIM = {2'b01, 61'd0};
    localparam t_q Q_ONE = {34'd0, 1'b1, 28'd0};
    localparam logic signed [63:0] S_LIM = {3'b001, 61'd0};

    localparam int QUO_W = 60;

    localparam t_cfg_idx CFG_FOCAL_X   = 3'd0;
    localparam t_cfg_idx CFG_FOCAL_Y   = 3'd1;
    localparam t_cfg_idx CFG_CENTER_X  = 3'd2;
    localparam t_cfg_idx CFG_CENTER_Y  = 3'd3;
    localparam t_cfg_idx CFG_RADIAL_K1 = 3'd4;
    localparam t_cfg_idx CFG_RADIAL_K2 = 3'd5;
    localparam t_cfg_idx CFG_RADIAL_K3 = 3'd6;
    localparam t_cfg_idx CFG_TANGENT   = 3'd7;

    // Sum of two words, saturated to magnitude 2^61.
    function automatic t_q sat_add(input t_q a, input t_q b);
        logic signed [63:0] s;
        t_q r;
        s = $signed({a[62], a}) + $signed({b[62], b});
        if (s > S_LIM) begin
            r = Q_LIM;
        end else if (s < -S_LIM) begin
            r = -Q_LIM;
        end else begin
            r = s[62:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/dpp_in_if.sv
// Input channel of the projection block: one camera-frame point and a pyramid level.
// No dependencies.
interface dpp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [1:0]         pyramid_level;

    modport source (output valid, point_x, point_y, point_z, pyramid_level, input ready);
    modport sink   (input valid, point_x, point_y, point_z, pyramid_level, output ready);
endinterface

FILE: hdl/dpp_out_if.sv
// Output channel of the projection block: one pixel position and its validity.
// No dependencies.
interface dpp_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] pixel_u;
    logic [19:0] pixel_v;
    logic        valid_res;

    modport source (output valid, pixel_u, pixel_v, valid_res, input ready);
    modport sink   (input valid, pixel_u, pixel_v, valid_res, output ready);
endinterface

FILE: hdl/dpp_dly.sv
// Enabled delay line of fixed depth used to align operands across the pipeline.
// No dependencies.
module dpp_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_tap[k] <= '0;
        end else if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[N-1];
endmodule

FILE: hdl/dpp_mul.sv
// Four-stage signed multiplier with right shift, truncation toward zero and saturation.
// Depends on dpp_pkg for the word type and the saturation bound.
module dpp_mul #(
    parameter int SH = 28
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  dpp_pkg::t_q  i_a,
    input  dpp_pkg::t_q  i_b,
    output dpp_pkg::t_q  o_p
);
    logic [62:0]  w_abs_a, w_abs_b;
    logic [61:0]  r_ma, r_mb;
    logic         r_neg0, r_neg1, r_neg2;
    logic [63:0]  r_p00;
    logic [61:0]  r_p01, r_p10;
    logic [59:0]  r_p11;
    logic [123:0] r_prod;
    logic [123:0] w_shr;
    dpp_pkg::t_q  w_mag;
    dpp_pkg::t_q  r_p;

    assign w_abs_a = i_a[62] ? 63'(-i_a) : 63'(i_a);
    assign w_abs_b = i_b[62] ? 63'(-i_b) : 63'(i_b);

    // Magnitudes are split into a 32-bit low and a 30-bit high half.
    assign w_shr = r_prod >> SH;
    assign w_mag = (w_shr > 124'(dpp_pkg::Q_LIM)) ? dpp_pkg::Q_LIM : w_shr[62:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= w_abs_a[61:0];
            r_mb   <= w_abs_b[61:0];
            r_neg0 <= i_a[62] ^ i_b[62];
            r_p00  <= r_ma[31:0] * r_mb[31:0];
            r_p01  <= r_ma[31:0] * r_mb[61:32];
            r_p10  <= r_ma[61:32] * r_mb[31:0];
            r_p11  <= r_ma[61:32] * r_mb[61:32];
            r_neg1 <= r_neg0;
            r_prod <= 124'(r_p00) + (124'(r_p01) << 32) + (124'(r_p10) << 32)
                    + (124'(r_p11) << 64);
            r_neg2 <= r_neg1;
            r_p    <= r_neg2 ? -w_mag : w_mag;
        end
    end

    assign o_p = r_p;
endmodule

FILE: hdl/dpp_div.sv
// Pipelined restoring divider: both point coordinates times 2^28 over the depth,
// one quotient bit per stage. Depends on dpp_pkg for the word type and quotient width.
module dpp_div #(
    parameter int SW = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic [SW-1:0]      i_sb,
    output dpp_pkg::t_q        o_x,
    output dpp_pkg::t_q        o_y,
    output logic [SW-1:0]      o_sb
);
    localparam int QW = dpp_pkg::QUO_W;

    logic [QW-1:0] r_acc_x [QW+1];
    logic [QW-1:0] r_acc_y [QW+1];
    logic [30:0]   r_rem_x [QW+1];
    logic [30:0]   r_rem_y [QW+1];
    logic [30:0]   r_dvs   [QW+1];
    logic          r_sx    [QW+1];
    logic          r_sy    [QW+1];
    logic [SW-1:0] r_sb    [QW+1];
    dpp_pkg::t_q   r_x, r_y;
    logic [SW-1:0] r_sb_o;
    logic [31:0]   w_ax, w_ay;

    assign w_ax = i_px[31] ? 32'(-i_px) : 32'(i_px);
    assign w_ay = i_py[31] ? 32'(-i_py) : 32'(i_py);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc_x[0] <= {w_ax, 28'd0};
            r_acc_y[0] <= {w_ay, 28'd0};
            r_rem_x[0] <= '0;
            r_rem_y[0] <= '0;
            r_dvs[0]   <= i_pz[30:0];
            r_sx[0]    <= i_px[31];
            r_sy[0]    <= i_py[31];
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [31:0] w_tx, w_ty;
        logic        w_gx, w_gy;
        logic [31:0] w_dx, w_dy;

        assign w_tx = {r_rem_x[g], r_acc_x[g][QW-1]};
        assign w_ty = {r_rem_y[g], r_acc_y[g][QW-1]};
        assign w_gx = w_tx >= {1'b0, r_dvs[g]};
        assign w_gy = w_ty >= {1'b0, r_dvs[g]};
        assign w_dx = w_gx ? w_tx - {1'b0, r_dvs[g]} : w_tx;
        assign w_dy = w_gy ? w_ty - {1'b0, r_dvs[g]} : w_ty;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[g+1] <= w_dx[30:0];
                r_rem_y[g+1] <= w_dy[30:0];
                r_acc_x[g+1] <= {r_acc_x[g][QW-2:0], w_gx};
                r_acc_y[g+1] <= {r_acc_y[g][QW-2:0], w_gy};
                r_dvs[g+1]   <= r_dvs[g];
                r_sx[g+1]    <= r_sx[g];
                r_sy[g+1]    <= r_sy[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) r_sb[k] <= '0;
            r_sb_o <= '0;
        end else if (i_en) begin
            r_sb[0] <= i_sb;
            for (int k = 1; k <= QW; k++) r_sb[k] <= r_sb[k-1];
            r_sb_o <= r_sb[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= r_sx[QW] ? -dpp_pkg::t_q'(r_acc_x[QW]) : dpp_pkg::t_q'(r_acc_x[QW]);
            r_y <= r_sy[QW] ? -dpp_pkg::t_q'(r_acc_y[QW]) : dpp_pkg::t_q'(r_acc_y[QW]);
        end
    end

    assign o_x  = r_x;
    assign o_y  = r_y;
    assign o_sb = r_sb_o;
endmodule

FILE: hdl/distorted_pinhole_projection_top.sv
// Top level of the distorted pinhole projection: configuration registers and the pipeline.
// Depends on dpp_pkg, dpp_in_if, dpp_out_if, dpp_div, dpp_mul and dpp_dly.
//
//   channel   direction  carries
//   i_pt      in         point_x, point_y, point_z (Q16.16), pyramid_level
//   o_pix     out        pixel_u, pixel_v (Q12.8), valid_res
//   i_cfg_*   in         register write: enable, index 0 to 7, 64-bit data
//
// The block takes one item per clock unless its output stalls. Each item passes the
// restoring divider (one quotient bit per stage), then multipliers and registered
// saturating adders, then the output register. All stages advance together; when the
// output item is not taken the whole pipeline holds, so nothing is lost or repeated.
// Reset is synchronous and clears the valid bits and loads the register defaults; no
// item is taken while reset is asserted.
module distorted_pinhole_projection_top #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    dpp_in_if.sink      i_pt,
    dpp_out_if.source   o_pix
);
    // Bounds of the unscaled position in Q.28; the test is the same at every level.
    localparam dpp_pkg::t_q U_LIM = dpp_pkg::t_q'(IMAGE_WIDTH) << 28;
    localparam dpp_pkg::t_q V_LIM = dpp_pkg::t_q'(IMAGE_HEIGHT) << 28;
    localparam int SBW = 4;

    // Configuration registers.
    logic [23:0]        r_fx, r_fy, r_cx, r_cy;
    logic signed [31:0] r_k1, r_k2, r_k3;
    logic [63:0]        r_tp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 24'd2048000;
            r_fy <= 24'd2048000;
            r_cx <= 24'd1310720;
            r_cy <= 24'd983040;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_tp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpp_pkg::CFG_FOCAL_X:   r_fx <= i_cfg_data[23:0];
                dpp_pkg::CFG_FOCAL_Y:   r_fy <= i_cfg_data[23:0];
                dpp_pkg::CFG_CENTER_X:  r_cx <= i_cfg_data[23:0];
                dpp_pkg::CFG_CENTER_Y:  r_cy <= i_cfg_data[23:0];
                dpp_pkg::CFG_RADIAL_K1: r_k1 <= i_cfg_data[31:0];
                dpp_pkg::CFG_RADIAL_K2: r_k2 <= i_cfg_data[31:0];
                dpp_pkg::CFG_RADIAL_K3: r_k3 <= i_cfg_data[31:0];
                dpp_pkg::CFG_TANGENT:   r_tp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpp_pkg::t_q w_k1, w_k2, w_k3, w_p1, w_p2, w_fx, w_fy, w_cx, w_cy;
    assign w_k1 = dpp_pkg::t_q'(r_k1);
    assign w_k2 = dpp_pkg::t_q'(r_k2);
    assign w_k3 = dpp_pkg::t_q'(r_k3);
    assign w_p1 = dpp_pkg::t_q'($signed(r_tp[31:0]));
    assign w_p2 = dpp_pkg::t_q'($signed(r_tp[63:32]));
    assign w_fx = dpp_pkg::t_q'(r_fx);
    assign w_fy = dpp_pkg::t_q'(r_fy);
    assign w_cx = dpp_pkg::t_q'(r_cx) << 16;
    assign w_cy = dpp_pkg::t_q'(r_cy) << 16;

    // Global advance: every stage moves when the output register is empty or being taken.
    logic r_out_vld;
    logic w_en;
    assign w_en       = !r_out_vld || o_pix.ready;
    assign i_pt.ready = w_en && i_rst_n;

    // Sideband carries the item's valid bit, its level and whether the depth is positive.
    logic [SBW-1:0] w_sb_in, w_sb0, w_sb29;
    logic           w_zpos;
    assign w_zpos  = !i_pt.point_z[31] && (i_pt.point_z != '0);
    assign w_sb_in = {i_pt.valid, i_pt.pyramid_level, w_zpos};

    dpp_pkg::t_q w_x, w_y;

    dpp_div #(.SW(SBW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_px(i_pt.point_x), .i_py(i_pt.point_y), .i_pz(i_pt.point_z),
        .i_sb(w_sb_in), .o_x(w_x), .o_y(w_y), .o_sb(w_sb0)
    );

    dpp_pkg::t_q w_xx, w_yy, w_xy;
    dpp_pkg::t_q r_r2, r_xx2, r_yy2, r_xy2;
    dpp_pkg::t_q r_tx2, r_ty2;
    dpp_pkg::t_q w_r4, w_kr2, w_pa, w_pd;
    dpp_pkg::t_q w_pb, w_pc;
    dpp_pkg::t_q r_rad1;
    dpp_pkg::t_q w_r2d, w_rad1d, w_r6, w_kr4;
    dpp_pkg::t_q r_rad2;
    dpp_pkg::t_q w_rad2d, w_kr6;
    dpp_pkg::t_q r_rad3, w_xd18, w_yd18;
    dpp_pkg::t_q w_xd0, w_yd0, w_pa_d, w_pc_d;
    dpp_pkg::t_q r_xd1, r_yd1, w_pb_d, w_pd_d;
    dpp_pkg::t_q r_xd, r_yd;
    dpp_pkg::t_q w_mu, w_mv;
    dpp_pkg::t_q r_u, r_v;

    dpp_mul #(.SH(28)) u_mxx (.i_clk(i_clk), .i_en(w_en), .i_a(w_x), .i_b(w_x), .o_p(w_xx));
    dpp_mul #(.SH(28)) u_myy (.i_clk(i_clk), .i_en(w_en), .i_a(w_y), .i_b(w_y), .o_p(w_yy));
    dpp_mul #(.SH(28)) u_mxy (.i_clk(i_clk), .i_en(w_en), .i_a(w_x), .i_b(w_y), .o_p(w_xy));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2  <= dpp_pkg::sat_add(w_xx, w_yy);
            r_xx2 <= dpp_pkg::sat_add(w_xx, w_xx);
            r_yy2 <= dpp_pkg::sat_add(w_yy, w_yy);
            r_xy2 <= dpp_pkg::sat_add(w_xy, w_xy);
            r_tx2 <= dpp_pkg::sat_add(r_r2, r_xx2);
            r_ty2 <= dpp_pkg::sat_add(r_r2, r_yy2);
        end
    end

    // Radial polynomial, summed in the order 1 + k1 r2, then + k2 r4, then + k3 r6.
    dpp_mul #(.SH(28)) u_mr4 (.i_clk(i_clk), .i_en(w_en), .i_a(r_r2), .i_b(r_r2), .o_p(w_r4));
    dpp_mul #(.SH(28)) u_mk1 (.i_clk(i_clk), .i_en(w_en), .i_a(w_k1), .i_b(r_r2), .o_p(w_kr2));
    dpp_dly #(.W(63), .N(4)) u_dr2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                    .i_d(r_r2), .o_q(w_r2d));
    dpp_mul #(.SH(28)) u_mr6 (.i_clk(i_clk), .i_en(w_en), .i_a(w_r4), .i_b(w_r2d), .o_p(w_r6));
    dpp_mul #(.SH(28)) u_mk2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_k2), .i_b(w_r4), .o_p(w_kr4));
    dpp_mul #(.SH(28)) u_mk3 (.i_clk(i_clk), .i_en(w_en), .i_a(w_k3), .i_b(w_r6), .o_p(w_kr6));

    dpp_dly #(.W(63), .N(3)) u_dra1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                     .i_d(r_rad1), .o_q(w_rad1d));
    dpp_dly #(.W(63), .N(3)) u_dra2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                     .i_d(r_rad2), .o_q(w_rad2d));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad1 <= dpp_pkg::sat_add(dpp_pkg::Q_ONE, w_kr2);
            r_rad2 <= dpp_pkg::sat_add(w_rad1d, w_kr4);
            r_rad3 <= dpp_pkg::sat_add(w_rad2d, w_kr6);
        end
    end

    // Tangential terms: p1*2xy and p2*(r2+2x^2) for columns, p1*(r2+2y^2) and p2*2xy for rows.
    dpp_mul #(.SH(28)) u_mpa (.i_clk(i_clk), .i_en(w_en), .i_a(w_p1), .i_b(r_xy2), .o_p(w_pa));
    dpp_mul #(.SH(28)) u_mpb (.i_clk(i_clk), .i_en(w_en), .i_a(w_p2), .i_b(r_tx2), .o_p(w_pb));
    dpp_mul #(.SH(28)) u_mpc (.i_clk(i_clk), .i_en(w_en), .i_a(w_p1), .i_b(r_ty2), .o_p(w_pc));
    dpp_mul #(.SH(28)) u_mpd (.i_clk(i_clk), .i_en(w_en), .i_a(w_p2), .i_b(r_xy2), .o_p(w_pd));

    dpp_dly #(.W(63), .N(13)) u_dpa (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                     .i_d(w_pa), .o_q(w_pa_d));
    dpp_dly #(.W(63), .N(13)) u_dpb (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                     .i_d(w_pb), .o_q(w_pb_d));
    dpp_dly #(.W(63), .N(12)) u_dpc (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                     .i_d(w_pc), .o_q(w_pc_d));
    dpp_dly #(.W(63), .N(14)) u_dpd (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                     .i_d(w_pd), .o_q(w_pd_d));

    // Distorted coordinates.
    dpp_dly #(.W(63), .N(18)) u_dx (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                    .i_d(w_x), .o_q(w_xd18));
    dpp_dly #(.W(63), .N(18)) u_dy (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                    .i_d(w_y), .o_q(w_yd18));
    dpp_mul #(.SH(28)) u_mxd (.i_clk(i_clk), .i_en(w_en), .i_a(w_xd18), .i_b(r_rad3),
                              .o_p(w_xd0));
    dpp_mul #(.SH(28)) u_myd (.i_clk(i_clk), .i_en(w_en), .i_a(w_yd18), .i_b(r_rad3),
                              .o_p(w_yd0));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd1 <= dpp_pkg::sat_add(w_xd0, w_pa_d);
            r_yd1 <= dpp_pkg::sat_add(w_yd0, w_pc_d);
            r_xd  <= dpp_pkg::sat_add(r_xd1, w_pb_d);
            r_yd  <= dpp_pkg::sat_add(r_yd1, w_pd_d);
        end
    end

    // Pixel mapping at full resolution in Q.28.
    dpp_mul #(.SH(12)) u_mfu (.i_clk(i_clk), .i_en(w_en), .i_a(w_fx), .i_b(r_xd), .o_p(w_mu));
    dpp_mul #(.SH(12)) u_mfv (.i_clk(i_clk), .i_en(w_en), .i_a(w_fy), .i_b(r_yd), .o_p(w_mv));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u <= dpp_pkg::sat_add(w_mu, w_cx);
            r_v <= dpp_pkg::sat_add(w_mv, w_cy);
        end
    end

    dpp_dly #(.W(SBW), .N(29)) u_dsb (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
                                      .i_d(w_sb0), .o_q(w_sb29));

    // Range test and level scaling, then the output register.
    logic        w_ok;
    logic [1:0]  w_lvl;
    logic [19:0] w_pu, w_pv;
    logic        r_res;
    logic [19:0] r_pu, r_pv;

    assign w_lvl = w_sb29[2:1];
    assign w_ok  = w_sb29[0] && !r_u[62] && (r_u < U_LIM) && !r_v[62] && (r_v < V_LIM);
    assign w_pu  = r_u[39:20] >> w_lvl;
    assign w_pv  = r_v[39:20] >> w_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_sb29[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= w_ok;
            r_pu  <= w_ok ? w_pu : '0;
            r_pv  <= w_ok ? w_pv : '0;
        end
    end

    assign o_pix.valid     = r_out_vld;
    assign o_pix.valid_res = r_res;
    assign o_pix.pixel_u   = r_pu;
    assign o_pix.pixel_v   = r_pv;

    // A rejected point reports a zero position.
    a_zero_when_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res) |-> (r_pu == '0 && r_pv == '0))
        else $error("rejected item carries a nonzero position");

    // An accepted position lies inside the full-resolution image.
    a_inside_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res) |-> (r_pu < 20'(IMAGE_WIDTH * 256) &&
                                  r_pv < 20'(IMAGE_HEIGHT * 256)))
        else $error("accepted position outside the image");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_vld)
        else $error("output valid after reset");

endmodule
